@@ design/rfr_pkg.sv @@
// Shared types and constants for the reference frame ring manager.
// Holds the request/response word structs, the stage record and the CSR codes.
// No dependencies.
package rfr_pkg;

   localparam int ORDER_W   = 16;
   localparam int RECENCY_W = 4;
   localparam int SLOT_OUT_W = 4;
   localparam int ADDR_W    = 30;
   localparam int HELD_W    = 5;
   localparam int DEPTH_W   = 5;
   localparam int FBYTES_W  = 26;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 26;

   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_DEPTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES = 2'd1;

   localparam logic [DEPTH_W-1:0]  RING_DEPTH_RESET  = 5'd4;
   localparam logic [FBYTES_W-1:0] FRAME_BYTES_RESET = 26'd6220800;

   typedef struct packed {
      logic                        cmd;
      logic signed [ORDER_W-1:0]   order_count;
      logic [RECENCY_W-1:0]        recency_index;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic [SLOT_OUT_W-1:0]       slot_index;
      logic signed [ORDER_W-1:0]   slot_order_count;
      logic [ADDR_W-1:0]           frame_address;
      logic [HELD_W-1:0]           frames_held;
   } rsp_type;

   // Record carried from the ring stage to the response stage.
   typedef struct packed {
      logic                        valid;
      logic                        push;
      logic                        found;
      logic signed [ORDER_W-1:0]   order_count;
      logic [HELD_W-1:0]           frames_held;
   } stage_type;

endpackage

@@ design/rfr_order_mem.sv @@
// Order count storage for the ring slots: one write or one registered read a cycle.
// Depends on rfr_pkg for the order count width.
module rfr_order_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 addr,
   input  logic signed [rfr_pkg::ORDER_W-1:0] wr_data,
   output logic signed [rfr_pkg::ORDER_W-1:0] rd_data
);

   logic signed [rfr_pkg::ORDER_W-1:0] mem [DEPTH];
   logic signed [rfr_pkg::ORDER_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rfr_ring_ctrl.sv @@
// Ring pointer state, configuration registers and slot selection for each word.
// Depends on rfr_pkg for word types and CSR codes.
module rfr_ring_ctrl #(
   parameter int MAX_REFS = 16,
   parameter int SLOT_W   = 4,
   parameter int CNT_W    = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [rfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               accept,
   input  logic                               advance,
   input  rfr_pkg::req_type                   req,
   output logic [SLOT_W-1:0]                  mem_addr,
   output logic                               mem_wr_en,
   output logic                               mem_rd_en,
   output logic [SLOT_W-1:0]                  stage_slot,
   output rfr_pkg::stage_type                 stage,
   output logic [rfr_pkg::FBYTES_W-1:0]       frame_bytes
);

   localparam int SUM_W = ((CNT_W > rfr_pkg::RECENCY_W) ? CNT_W : rfr_pkg::RECENCY_W) + 1;

   logic [rfr_pkg::DEPTH_W-1:0]  depth_ff;
   logic [rfr_pkg::FBYTES_W-1:0] fbytes_ff;
   logic [SLOT_W-1:0]            oldest_ff, oldest_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   rfr_pkg::stage_type           stage_ff, stage_in;

   logic [CNT_W-1:0]  depth_used;
   logic [SUM_W-1:0]  depth_ext;
   logic [SUM_W-1:0]  push_sum, push_wrap, next_sum, next_wrap, look_sum, look_wrap;
   logic              is_push, has_room, hit;

   // Clamp depth into 1..MAX_REFS.
   always_comb begin
      if (depth_ff == '0) begin
         depth_used = CNT_W'(1);
      end else if (32'(depth_ff) > MAX_REFS) begin
         depth_used = CNT_W'(MAX_REFS);
      end else begin
         depth_used = CNT_W'(depth_ff);
      end
   end

   assign depth_ext = SUM_W'(depth_used);
   assign is_push   = (req.cmd == rfr_pkg::CMD_PUSH);
   assign has_room  = (count_ff < depth_used);
   assign hit       = (SUM_W'(req.recency_index) < SUM_W'(count_ff));

   // Positions stay below twice the depth, so one subtract wraps them.
   assign push_sum  = SUM_W'(oldest_ff) + SUM_W'(count_ff);
   assign push_wrap = (push_sum >= depth_ext) ? push_sum - depth_ext : push_sum;
   assign next_sum  = SUM_W'(oldest_ff) + SUM_W'(1);
   assign next_wrap = (next_sum >= depth_ext) ? next_sum - depth_ext : next_sum;
   assign look_sum  = SUM_W'(oldest_ff) + SUM_W'(count_ff) - SUM_W'(1)
                      - SUM_W'(req.recency_index);
   assign look_wrap = (look_sum >= depth_ext) ? look_sum - depth_ext : look_sum;

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      if (is_push) begin
         if (has_room) begin
            slot_in  = SLOT_W'(push_wrap);
            count_in = count_ff + CNT_W'(1);
         end else begin
            slot_in   = oldest_ff;
            oldest_in = SLOT_W'(next_wrap);
         end
      end else begin
         slot_in = hit ? SLOT_W'(look_wrap) : '0;
      end
      stage_in.valid       = accept;
      stage_in.push        = is_push;
      stage_in.found       = is_push | hit;
      stage_in.order_count = req.order_count;
      stage_in.frames_held = rfr_pkg::HELD_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= rfr_pkg::RING_DEPTH_RESET;
         fbytes_ff <= rfr_pkg::FRAME_BYTES_RESET;
         oldest_ff <= '0;
         count_ff  <= '0;
         stage_ff  <= '0;
      end else begin
         if (csr_write_en && csr_index == rfr_pkg::CSR_RING_DEPTH) begin
            // A new depth empties the ring.
            depth_ff  <= rfr_pkg::DEPTH_W'(csr_wdata);
            oldest_ff <= '0;
            count_ff  <= '0;
         end else if (accept) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
         end
         if (csr_write_en && csr_index == rfr_pkg::CSR_FRAME_BYTES) begin
            fbytes_ff <= csr_wdata;
         end
         if (advance) begin
            stage_ff <= stage_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign mem_addr    = slot_in;
   assign mem_wr_en   = accept & is_push;
   assign mem_rd_en   = accept & ~is_push & hit;
   assign stage_slot  = slot_ff;
   assign stage       = stage_ff;
   assign frame_bytes = fbytes_ff;

endmodule

@@ design/rfr_rsp_stage.sv @@
// Response stage: frame address multiply, field selection and the output register.
// Depends on rfr_pkg for word types.
module rfr_rsp_stage #(
   parameter int SLOT_W = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  rfr_pkg::stage_type                 stage,
   input  logic [SLOT_W-1:0]                  stage_slot,
   input  logic signed [rfr_pkg::ORDER_W-1:0] mem_data,
   input  logic [rfr_pkg::FBYTES_W-1:0]       frame_bytes,
   output logic                               rsp_valid,
   output rfr_pkg::rsp_type                   rsp_word
);

   localparam int PROD_W = SLOT_W + rfr_pkg::FBYTES_W;

   logic              valid_ff;
   rfr_pkg::rsp_type  word_ff, word_in;
   logic [PROD_W-1:0] product;

   assign product = PROD_W'(stage_slot) * PROD_W'(frame_bytes);

   always_comb begin
      word_in.frames_held = stage.frames_held;
      if (stage.found) begin
         word_in.found            = 1'b1;
         word_in.slot_index       = rfr_pkg::SLOT_OUT_W'(stage_slot);
         word_in.slot_order_count = stage.push ? stage.order_count : mem_data;
         word_in.frame_address    = rfr_pkg::ADDR_W'(product);
      end else begin
         word_in.found            = 1'b0;
         word_in.slot_index       = '0;
         word_in.slot_order_count = '0;
         word_in.frame_address    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

@@ design/reference_frame_ring_manager_core.sv @@
// Reference frame ring manager: sliding-window ring of reference slots.
// Depends on rfr_pkg, rfr_ring_ctrl, rfr_order_mem and rfr_rsp_stage.
//
// Usage:
//   req channel (req_valid / req_stall / req_word): one word per command.
//     cmd = push stores order_count in the next slot (overwriting the oldest
//     once the ring is full); cmd = lookup finds the frame at recency_index,
//     0 being the newest.
//   rsp channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
//     request, in order, with slot, order count, base address (slot times
//     frame_bytes) and the number of frames held.
//   csr port: csr_write_en with csr_index 0 writes ring_depth (and empties the
//     ring), index 1 writes frame_bytes; other indexes are ignored.
//     Write only while no request is in flight.
// An accepted request reaches rsp_valid through two registered stages: slot
// selection and the order table read, then the address multiply. Throughput
// is one word per cycle; the two stages advance together, so req_stall rises
// in the cycle a held response is stalled.
// Synchronous reset empties the ring, restores ring_depth = 4 and frame_bytes = 6220800
// and drops any word in flight. The order table needs no clearing.
module reference_frame_ring_manager_core #(
   parameter int MAX_REFS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rfr_pkg::req_type               req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rfr_pkg::rsp_type               rsp_word,
   input  logic                           csr_write_en,
   input  logic [rfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_W  = $clog2(MAX_REFS + 1);

   logic                               advance;
   logic                               accept;
   logic [SLOT_W-1:0]                  mem_addr;
   logic                               mem_wr_en;
   logic                               mem_rd_en;
   logic signed [rfr_pkg::ORDER_W-1:0] mem_data;
   logic [SLOT_W-1:0]                  stage_slot;
   rfr_pkg::stage_type                 stage;
   logic [rfr_pkg::FBYTES_W-1:0]       frame_bytes;

   // Advance both stages whenever the output register is empty or being taken.
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~advance;
   assign accept    = req_valid & advance;

   rfr_ring_ctrl #(
      .MAX_REFS (MAX_REFS),
      .SLOT_W   (SLOT_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .advance      (advance),
      .req          (req_word),
      .mem_addr     (mem_addr),
      .mem_wr_en    (mem_wr_en),
      .mem_rd_en    (mem_rd_en),
      .stage_slot   (stage_slot),
      .stage        (stage),
      .frame_bytes  (frame_bytes)
   );

   rfr_order_mem #(
      .DEPTH  (MAX_REFS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (req_word.order_count),
      .rd_data (mem_data)
   );

   rfr_rsp_stage #(
      .SLOT_W (SLOT_W)
   ) u_rsp (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage       (stage),
      .stage_slot  (stage_slot),
      .mem_data    (mem_data),
      .frame_bytes (frame_bytes),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule
